// ===== hdl/bvct_pkg.sv =====
`default_nettype none
package bvct_pkg;

  // volume kinds
  localparam logic [1:0] KIND_BOX     = 2'd0;
  localparam logic [1:0] KIND_SPHERE  = 2'd1;
  localparam logic [1:0] KIND_CAPSULE = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  // result classes
  localparam logic [1:0] CLASS_NONE      = 2'd0;
  localparam logic [1:0] CLASS_CONTACT   = 2'd1;
  localparam logic [1:0] CLASS_INTRUSION = 2'd2;

  // field widths fixed by the interface
  localparam int KIND_BITS      = 2;
  localparam int TOL_BITS       = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;
  // extents bits at or above this position read as zero
  localparam int EXT_FIELD_BITS = 64;

  localparam int DEF_COORD_BITS  = 16;
  localparam int DEF_EXTENT_BITS = 16;

  // decoded pair of kinds
  typedef struct packed {
    logic unsup;
    logic is_box;
    logic is_capsule;
  } pair_t;

  // interval test outcome for boxes
  typedef struct packed {
    logic loose;
    logic strict;
  } box_flags_t;

  // distance test outcome for spheres and capsules
  typedef struct packed {
    logic overlap;
    logic deep;
  } round_flags_t;

  function automatic pair_t decode_pair(input logic [KIND_BITS-1:0] ka,
                                        input logic [KIND_BITS-1:0] kb);
    pair_t p;
    p.unsup      = (ka != kb) || (ka == KIND_INVALID);
    p.is_box     = (ka == kb) && (ka == KIND_BOX);
    p.is_capsule = (ka == kb) && (ka == KIND_CAPSULE);
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bvct_box_test.sv =====
`default_nettype none
module bvct_box_test #(
  parameter int COORD_BITS  = bvct_pkg::DEF_COORD_BITS,
  parameter int EXTENT_BITS = bvct_pkg::DEF_EXTENT_BITS
) (
  input  wire logic [2:0][COORD_BITS-1:0]       pos_a,
  input  wire logic [2:0][COORD_BITS-1:0]       pos_b,
  input  wire logic [2:0][EXTENT_BITS-1:0]      ext_a,
  input  wire logic [2:0][EXTENT_BITS-1:0]      ext_b,
  input  wire logic [bvct_pkg::TOL_BITS-1:0]    tol,
  output bvct_pkg::box_flags_t                  flags
);

  localparam int MAXW0 = (COORD_BITS > EXTENT_BITS) ? COORD_BITS : EXTENT_BITS;
  localparam int MAXW1 = (MAXW0 > bvct_pkg::TOL_BITS) ? MAXW0 : bvct_pkg::TOL_BITS;
  localparam int BW    = MAXW1 + 4;

  logic [2:0] loose_ax;
  logic [2:0] strict_ax;
  logic signed [BW-1:0] eps;

  assign eps = {{(BW-bvct_pkg::TOL_BITS){1'b0}}, tol};

  // per-axis interval overlap, loose and strict
  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [BW-1:0] pa, pb, ea, eb;
    logic signed [BW-1:0] mina, maxa, minb, maxb;

    assign pa = {{(BW-COORD_BITS){pos_a[i][COORD_BITS-1]}}, pos_a[i]};
    assign pb = {{(BW-COORD_BITS){pos_b[i][COORD_BITS-1]}}, pos_b[i]};
    assign ea = {{(BW-EXTENT_BITS){1'b0}}, ext_a[i]};
    assign eb = {{(BW-EXTENT_BITS){1'b0}}, ext_b[i]};

    assign mina = pa - ea;
    assign maxa = pa + ea;
    assign minb = pb - eb;
    assign maxb = pb + eb;

    assign loose_ax[i]  = (mina <= maxb + eps) && (minb <= maxa + eps);
    assign strict_ax[i] = (mina <  maxb - eps) && (minb <  maxa - eps);
  end

  assign flags.loose  = &loose_ax;
  assign flags.strict = &strict_ax;

endmodule
`default_nettype wire

// ===== hdl/bvct_round_test.sv =====
`default_nettype none
module bvct_round_test #(
  parameter int COORD_BITS  = bvct_pkg::DEF_COORD_BITS,
  parameter int EXTENT_BITS = bvct_pkg::DEF_EXTENT_BITS
) (
  input  wire logic                             clk,
  input  wire logic [2:0][COORD_BITS-1:0]       pos_a,
  input  wire logic [2:0][COORD_BITS-1:0]       pos_b,
  input  wire logic [EXTENT_BITS-1:0]           rad_a,
  input  wire logic [EXTENT_BITS-1:0]           rad_b,
  input  wire logic                             is_capsule,
  input  wire logic [bvct_pkg::TOL_BITS-1:0]    tol,
  output bvct_pkg::round_flags_t                flags
);

  localparam int AW  = COORD_BITS + 1;        // magnitude of a coordinate difference
  localparam int SW  = 2 * AW;                // one squared difference
  localparam int DW  = SW + 2;                // sum of three squares
  localparam int RW  = EXTENT_BITS + 1;       // sum of radii
  localparam int RRW = 2 * RW;                // squared sum of radii
  localparam int CW0 = (DW > RRW) ? DW : RRW;
  localparam int CW1 = (CW0 > bvct_pkg::TOL_BITS) ? CW0 : bvct_pkg::TOL_BITS;
  localparam int CW  = CW1 + 1;

  logic [2:0][SW-1:0] sq_nxt;
  logic [2:0][SW-1:0] sq_r;
  logic [RRW-1:0]     rr_nxt;
  logic [RRW-1:0]     rr_r;
  logic [RW-1:0]      rsum;

  // absolute differences and their squares; y is skipped for capsules
  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [AW-1:0] pa, pb, diff;
    logic [AW-1:0] mag;

    assign pa   = {pos_a[i][COORD_BITS-1], pos_a[i]};
    assign pb   = {pos_b[i][COORD_BITS-1], pos_b[i]};
    assign diff = pb - pa;
    assign mag  = diff[AW-1] ? AW'(-diff) : AW'(diff);

    if (i == 1) begin : g_y
      assign sq_nxt[i] = is_capsule ? '0 : SW'(mag) * SW'(mag);
    end else begin : g_xz
      assign sq_nxt[i] = SW'(mag) * SW'(mag);
    end
  end

  assign rsum   = {1'b0, rad_a} + {1'b0, rad_b};
  assign rr_nxt = RRW'(rsum) * RRW'(rsum);

  // product register
  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
    rr_r <= rr_nxt;
  end

  // sum and compare against the squared sum of radii, within the tolerance
  logic [CW-1:0] gap_sum;
  logic [CW-1:0] rr_ext;
  logic [CW-1:0] eps;

  assign gap_sum = CW'(sq_r[0]) + CW'(sq_r[1]) + CW'(sq_r[2]);
  assign rr_ext  = CW'(rr_r);
  assign eps     = CW'(tol);

  assign flags.overlap = gap_sum < rr_ext + eps;
  assign flags.deep    = rr_ext >= gap_sum + eps;

endmodule
`default_nettype wire

// ===== hdl/bounding_volume_collision_test.sv =====
// A word taken at a clock edge passes through the input, product and result registers to the
// out_ ports, strobed by out_valid for one cycle.
// Throughput: one word per cycle; busy stays low, and the receiver cannot stall.
// The squared distance path sets the pipeline depth: one multiply stage, one sum/compare.
// Reset (rst_n low, synchronous) clears the pipeline valid bits and sets tolerance to 1.
`default_nettype none
module bounding_volume_collision_test #(
  parameter int COORD_BITS  = bvct_pkg::DEF_COORD_BITS,
  parameter int EXTENT_BITS = bvct_pkg::DEF_EXTENT_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // command input
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [bvct_pkg::KIND_BITS-1:0]    in_kind_a,
  input  wire logic [bvct_pkg::KIND_BITS-1:0]    in_kind_b,
  input  wire logic [COORD_BITS-1:0]             in_a_pos_x,
  input  wire logic [COORD_BITS-1:0]             in_a_pos_y,
  input  wire logic [COORD_BITS-1:0]             in_a_pos_z,
  input  wire logic [COORD_BITS-1:0]             in_b_pos_x,
  input  wire logic [COORD_BITS-1:0]             in_b_pos_y,
  input  wire logic [COORD_BITS-1:0]             in_b_pos_z,
  input  wire logic [3*EXTENT_BITS-1:0]          in_extents_a,
  input  wire logic [3*EXTENT_BITS-1:0]          in_extents_b,
  // result strobe
  output logic                                   out_valid,
  output logic [1:0]                             out_collision_class,
  output logic                                   out_unsupported_pair,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [bvct_pkg::TOL_BITS-1:0]     cfg_wdata
);

  localparam int XW = 3 * EXTENT_BITS;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // tolerance register
  logic [bvct_pkg::TOL_BITS-1:0] tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= bvct_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // extents bits beyond the 64-bit field read as zero
  logic [XW-1:0] ext_a_lim;
  logic [XW-1:0] ext_b_lim;
  for (genvar k = 0; k < XW; k++) begin : g_lim
    if (k < bvct_pkg::EXT_FIELD_BITS) begin : g_keep
      assign ext_a_lim[k] = in_extents_a[k];
      assign ext_b_lim[k] = in_extents_b[k];
    end else begin : g_drop
      assign ext_a_lim[k] = 1'b0;
      assign ext_b_lim[k] = 1'b0;
    end
  end

  // input register
  logic                               in_vld_r;
  bvct_pkg::pair_t                    in_pair_r;
  logic [2:0][COORD_BITS-1:0]         pa_r;
  logic [2:0][COORD_BITS-1:0]         pb_r;
  logic [2:0][EXTENT_BITS-1:0]        ea_r;
  logic [2:0][EXTENT_BITS-1:0]        eb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_pair_r <= bvct_pkg::decode_pair(in_kind_a, in_kind_b);
      pa_r      <= {in_a_pos_z, in_a_pos_y, in_a_pos_x};
      pb_r      <= {in_b_pos_z, in_b_pos_y, in_b_pos_x};
      ea_r      <= ext_a_lim;
      eb_r      <= ext_b_lim;
    end
  end

  // box interval test
  bvct_pkg::box_flags_t box_flags;
  bvct_box_test #(
    .COORD_BITS  (COORD_BITS),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_box (
    .pos_a (pa_r),
    .pos_b (pb_r),
    .ext_a (ea_r),
    .ext_b (eb_r),
    .tol   (tol_r),
    .flags (box_flags)
  );

  // sphere / capsule distance test (holds its own product register)
  bvct_pkg::round_flags_t round_flags;
  bvct_round_test #(
    .COORD_BITS  (COORD_BITS),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_round (
    .clk        (clk),
    .pos_a      (pa_r),
    .pos_b      (pb_r),
    .rad_a      (ea_r[0]),
    .rad_b      (eb_r[0]),
    .is_capsule (in_pair_r.is_capsule),
    .tol        (tol_r),
    .flags      (round_flags)
  );

  // middle stage, aligned with the product register
  logic                  mid_vld_r;
  bvct_pkg::pair_t       mid_pair_r;
  bvct_pkg::box_flags_t  mid_box_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
    end else begin
      mid_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    mid_pair_r <= in_pair_r;
    mid_box_r  <= box_flags;
  end

  // class select
  logic [1:0] cls_nxt;
  always_comb begin
    cls_nxt = bvct_pkg::CLASS_NONE;
    if (mid_pair_r.unsup) begin
      cls_nxt = bvct_pkg::CLASS_NONE;
    end else if (mid_pair_r.is_box) begin
      if (mid_box_r.loose) begin
        cls_nxt = mid_box_r.strict ? bvct_pkg::CLASS_INTRUSION : bvct_pkg::CLASS_CONTACT;
      end
    end else if (round_flags.overlap) begin
      cls_nxt = round_flags.deep ? bvct_pkg::CLASS_INTRUSION : bvct_pkg::CLASS_CONTACT;
    end
  end

  // result register
  logic       out_vld_r;
  logic [1:0] out_cls_r;
  logic       out_unsup_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= mid_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_cls_r   <= cls_nxt;
    out_unsup_r <= mid_pair_r.unsup;
  end

  assign out_valid            = out_vld_r;
  assign out_collision_class  = out_cls_r;
  assign out_unsupported_pair = out_unsup_r;

`ifndef SYNTHESIS
  // every accepted word comes out as a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted word not delivered after three cycles");

  // no result without an earlier accepted word
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result strobe without an accepted word");

  // an unsupported pair never reports a collision
  a_unsup_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unsupported_pair) |-> (out_collision_class == bvct_pkg::CLASS_NONE))
    else $error("unsupported pair reported a collision");
`endif

endmodule
`default_nettype wire

// ===== tb/bounding_volume_collision_test_test.sv =====
`timescale 1ns / 1ps
module bounding_volume_collision_test_test;
  import bvct_pkg::*;

  localparam int POS_BITS       = DEF_COORD_BITS;
  localparam int LANE_BITS      = DEF_EXTENT_BITS;
  localparam int PHASE_WORDS    = 150;
  localparam int STEADY_WORDS   = 120;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 300;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [KIND_BITS-1:0]          kind_a;
    logic [KIND_BITS-1:0]          kind_b;
    logic [2:0][POS_BITS-1:0]      pos_a;
    logic [2:0][POS_BITS-1:0]      pos_b;
    logic [2:0][LANE_BITS-1:0]     ext_a;
    logic [2:0][LANE_BITS-1:0]     ext_b;
  } pair_word_t;

  typedef struct packed {
    logic [1:0] cls;
    logic       unsup;
  } verdict_t;

  // one line of the directed table: either a tolerance write or a word
  typedef struct packed {
    logic                is_tol;
    logic [TOL_BITS-1:0] tol;
    logic                typed;
    verdict_t            verdict;
    pair_word_t          word;
  } stim_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  pair_word_t          cmd       = '0;
  logic                cfg_we    = 1'b0;
  logic [TOL_BITS-1:0] cfg_wdata = '0;
  logic                busy;
  logic                out_valid;
  logic [1:0]          out_collision_class;
  logic                out_unsupported_pair;

  logic [TOL_BITS-1:0] tol_model = TOL_RESET;
  verdict_t            pending_verdicts[$];
  stim_row_t           directed_rows[$];
  int                  fault_count = 0;
  int                  idle_cycles = 0;

  always #2 clk = ~clk;

  bounding_volume_collision_test u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_kind_a            (cmd.kind_a),
    .in_kind_b            (cmd.kind_b),
    .in_a_pos_x           (cmd.pos_a[0]),
    .in_a_pos_y           (cmd.pos_a[1]),
    .in_a_pos_z           (cmd.pos_a[2]),
    .in_b_pos_x           (cmd.pos_b[0]),
    .in_b_pos_y           (cmd.pos_b[1]),
    .in_b_pos_z           (cmd.pos_b[2]),
    .in_extents_a         (cmd.ext_a),
    .in_extents_b         (cmd.ext_b),
    .out_valid            (out_valid),
    .out_collision_class  (out_collision_class),
    .out_unsupported_pair (out_unsupported_pair),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata)
  );

  // overlap class of one pair under a given tolerance
  function automatic verdict_t classify_pair(pair_word_t w, logic [TOL_BITS-1:0] tol);
    verdict_t v;
    longint   eps, pa, pb, ea, eb, gap_sq, reach_sq;
    bit       loose, strict;
    int       i;
    v   = '0;
    eps = longint'(tol);
    if (w.kind_a != w.kind_b || w.kind_a == KIND_INVALID) begin
      v.unsup = 1'b1;
    end else if (w.kind_a == KIND_BOX) begin
      loose  = 1'b1;
      strict = 1'b1;
      for (i = 0; i < 3; i++) begin
        pa = longint'($signed(w.pos_a[i]));
        pb = longint'($signed(w.pos_b[i]));
        ea = longint'(w.ext_a[i]);
        eb = longint'(w.ext_b[i]);
        if (!(pa - ea <= pb + eb + eps && pb - eb <= pa + ea + eps)) loose = 1'b0;
        if (!(pa - ea < pb + eb - eps && pb - eb < pa + ea - eps)) strict = 1'b0;
      end
      v.cls = loose ? (strict ? CLASS_INTRUSION : CLASS_CONTACT) : CLASS_NONE;
    end else begin
      // capsules drop the vertical axis
      gap_sq = 0;
      for (i = 0; i < 3; i++) begin
        if (!(w.kind_a == KIND_CAPSULE && i == 1)) begin
          pa = longint'($signed(w.pos_a[i]));
          pb = longint'($signed(w.pos_b[i]));
          gap_sq += (pb - pa) * (pb - pa);
        end
      end
      ea       = longint'(w.ext_a[0]);
      eb       = longint'(w.ext_b[0]);
      reach_sq = (ea + eb) * (ea + eb);
      if (gap_sq >= reach_sq + eps) v.cls = CLASS_NONE;
      else if (gap_sq + eps > reach_sq) v.cls = CLASS_CONTACT;
      else v.cls = CLASS_INTRUSION;
    end
    return v;
  endfunction

  function automatic pair_word_t pack_pair(logic [KIND_BITS-1:0] ka, logic [KIND_BITS-1:0] kb,
                                           int ax, int ay, int az, int bx, int by, int bz,
                                           logic [3*LANE_BITS-1:0] ea,
                                           logic [3*LANE_BITS-1:0] eb);
    pair_word_t w;
    w.kind_a   = ka;
    w.kind_b   = kb;
    w.pos_a[0] = ax[POS_BITS-1:0];
    w.pos_a[1] = ay[POS_BITS-1:0];
    w.pos_a[2] = az[POS_BITS-1:0];
    w.pos_b[0] = bx[POS_BITS-1:0];
    w.pos_b[1] = by[POS_BITS-1:0];
    w.pos_b[2] = bz[POS_BITS-1:0];
    w.ext_a    = ea;
    w.ext_b    = eb;
    return w;
  endfunction

  task automatic add_word(pair_word_t w, bit typed, logic [1:0] cls, logic unsup);
    stim_row_t row;
    row               = '0;
    row.typed         = typed;
    row.verdict.cls   = cls;
    row.verdict.unsup = unsup;
    row.word          = w;
    directed_rows.push_back(row);
  endtask

  task automatic add_tol(logic [TOL_BITS-1:0] v);
    stim_row_t row;
    row        = '0;
    row.is_tol = 1'b1;
    row.tol    = v;
    directed_rows.push_back(row);
  endtask

  // random pair: mostly same-kind bodies placed near the overlap boundary
  function automatic pair_word_t make_pair(logic [TOL_BITS-1:0] tol);
    pair_word_t w;
    int         i, mode, span, lead, reach, off;
    logic [1:0] k;
    for (i = 0; i < 3; i++) begin
      w.pos_a[i] = POS_BITS'($urandom);
      w.pos_b[i] = POS_BITS'($urandom);
      w.ext_a[i] = LANE_BITS'($urandom);
      w.ext_b[i] = LANE_BITS'($urandom);
    end
    w.kind_a = KIND_BITS'($urandom);
    w.kind_b = KIND_BITS'($urandom);
    mode = int'($urandom_range(0, 9));
    if (mode < 2) return w;

    k        = 2'($urandom_range(0, 2));
    w.kind_a = k;
    w.kind_b = ($urandom_range(0, 9) == 0) ? 2'($urandom) : k;
    for (i = 0; i < 3; i++) begin
      if ($urandom_range(0, 3) != 0) w.ext_a[i] = LANE_BITS'($urandom_range(0, 400));
      if ($urandom_range(0, 3) != 0) w.ext_b[i] = LANE_BITS'($urandom_range(0, 400));
    end
    span = ((tol > 60) ? 60 : int'(tol)) + 4;

    if (k == KIND_BOX) begin
      for (i = 0; i < 3; i++) begin
        reach = int'(w.ext_a[i]) + int'(w.ext_b[i]);
        case ($urandom_range(0, 2))
          0:       off = reach + int'($urandom_range(0, 2 * span)) - span;
          1:       off = int'($urandom_range(0, reach));
          default: off = int'($urandom_range(0, 2000));
        endcase
        if ($urandom_range(0, 1) == 1) off = -off;
        w.pos_b[i] = w.pos_a[i] + POS_BITS'(off);
      end
    end else begin
      // separation along one lead axis, the others equal or nearly so
      lead  = (k == KIND_CAPSULE) ? 2 * int'($urandom_range(0, 1))
                                  : int'($urandom_range(0, 2));
      reach = int'(w.ext_a[0]) + int'(w.ext_b[0]);
      for (i = 0; i < 3; i++) begin
        if (i == lead) begin
          if (mode < 4) off = int'($urandom_range(0, reach));
          else off = reach + int'($urandom_range(0, 8)) - 4;
        end else begin
          off = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 6)) - 3 : 0;
        end
        if ($urandom_range(0, 1) == 1) off = -off;
        w.pos_b[i] = w.pos_a[i] + POS_BITS'(off);
      end
      if (k == KIND_CAPSULE && $urandom_range(0, 1) == 1) w.pos_b[1] = POS_BITS'($urandom);
    end
    return w;
  endfunction

  task automatic flag_fault(string what, verdict_t want, verdict_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display("%0t: %s: expected class %0d unsup %0d, got class %0d unsup %0d",
               $realtime, what, want.cls, want.unsup, got.cls, got.unsup);
  endtask

  // offer a word and hold it until the block takes it
  task automatic send_word(pair_word_t w, verdict_t want);
    cmd   <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_verdicts.push_back(want);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_BITS-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tol_model = v;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    verdict_t want, got;
    if (rst_n && out_valid === 1'b1) begin
      got.cls   = out_collision_class;
      got.unsup = out_unsupported_pair;
      if (pending_verdicts.size() == 0) begin
        flag_fault("result with nothing pending", '0, got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got.cls !== want.cls) flag_fault("collision_class mismatch", want, got);
        if (got.unsup !== want.unsup) flag_fault("unsupported_pair mismatch", want, got);
      end
    end
  end

  // watchdog on cycles with no word taken and no result
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL bounding_volume_collision_test");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t           row;
    pair_word_t          w;
    verdict_t            want;
    logic [TOL_BITS-1:0] phase_tols [5];
    int                  idle_odds [5];
    int                  p, n;
    bit                  steady;

    // kind pairs and the degenerate zero-size bodies
    add_word(pack_pair(KIND_BOX, KIND_BOX, 0, 0, 0, 0, 0, 0, 48'h0, 48'h0),
             1'b1, CLASS_CONTACT, 1'b0);
    add_word(pack_pair(KIND_SPHERE, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 48'h0, 48'h0),
             1'b1, CLASS_CONTACT, 1'b0);
    add_word(pack_pair(KIND_CAPSULE, KIND_CAPSULE, 0, 0, 0, 0, 0, 0, 48'h0, 48'h0),
             1'b1, CLASS_CONTACT, 1'b0);
    add_word(pack_pair(KIND_INVALID, KIND_INVALID, 0, 0, 0, 0, 0, 0, 48'h0, 48'h0),
             1'b1, CLASS_NONE, 1'b1);
    add_word(pack_pair(KIND_BOX, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 48'h5, 48'h5),
             1'b1, CLASS_NONE, 1'b1);
    add_word(pack_pair(KIND_SPHERE, KIND_CAPSULE, 0, 0, 0, 0, 0, 0, 48'h5, 48'h5),
             1'b1, CLASS_NONE, 1'b1);
    add_word(pack_pair(KIND_CAPSULE, KIND_BOX, 0, 0, 0, 0, 0, 0, 48'h5, 48'h5),
             1'b1, CLASS_NONE, 1'b1);
    add_word(pack_pair(KIND_BOX, KIND_INVALID, 0, 0, 0, 0, 0, 0, 48'h5, 48'h5),
             1'b1, CLASS_NONE, 1'b1);
    add_word(pack_pair(KIND_INVALID, KIND_CAPSULE, 0, 0, 0, 0, 0, 0, 48'h5, 48'h5),
             1'b1, CLASS_NONE, 1'b1);
    // coordinate and extent extremes
    add_word(pack_pair(KIND_BOX, KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767,
                       48'h0, 48'h0), 1'b1, CLASS_NONE, 1'b0);
    add_word(pack_pair(KIND_BOX, KIND_BOX, 32767, 32767, 32767, -32768, -32768, -32768,
                       48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF), 1'b1, CLASS_INTRUSION, 1'b0);
    add_word(pack_pair(KIND_SPHERE, KIND_SPHERE, -32768, -32768, -32768, 32767, 32767, 32767,
                       48'hFFFF_FFFF_FFFF, 48'h0000_0000_FFFF), 1'b0, CLASS_NONE, 1'b0);
    add_word(pack_pair(KIND_SPHERE, KIND_SPHERE, -32768, -32768, -32768, 32767, 32767, 32767,
                       48'h0, 48'h0), 1'b1, CLASS_NONE, 1'b0);
    // capsules ignore the vertical axis
    add_word(pack_pair(KIND_CAPSULE, KIND_CAPSULE, 7, -32768, -3, 7, 32767, -3,
                       48'h0000_0000_0001, 48'hFFFF_FFFF_0001), 1'b0, CLASS_NONE, 1'b0);
    add_word(pack_pair(KIND_CAPSULE, KIND_CAPSULE, 0, 0, 0, 40, 0, 0,
                       48'h0000_0000_0005, 48'h0000_0000_0005), 1'b0, CLASS_NONE, 1'b0);
    // box faces touching, apart by the tolerance, apart by more
    add_word(pack_pair(KIND_BOX, KIND_BOX, 0, 0, 0, 10, 0, 0,
                       48'h0005_0005_0005, 48'h0005_0005_0005), 1'b0, CLASS_NONE, 1'b0);
    add_word(pack_pair(KIND_BOX, KIND_BOX, 0, 0, 0, 11, 0, 0,
                       48'h0005_0005_0005, 48'h0005_0005_0005), 1'b0, CLASS_NONE, 1'b0);
    add_word(pack_pair(KIND_BOX, KIND_BOX, 0, 0, 0, 12, 0, 0,
                       48'h0005_0005_0005, 48'h0005_0005_0005), 1'b0, CLASS_NONE, 1'b0);
    // spheres exactly touching and just apart
    add_word(pack_pair(KIND_SPHERE, KIND_SPHERE, 0, 0, 0, 10, 0, 0,
                       48'h0000_0000_0005, 48'h0000_0000_0005), 1'b0, CLASS_NONE, 1'b0);
    add_word(pack_pair(KIND_SPHERE, KIND_SPHERE, 0, 0, 0, 10, 1, 0,
                       48'h0000_0000_0005, 48'h0000_0000_0005), 1'b0, CLASS_NONE, 1'b0);
    // zero tolerance: closed versus open overlap, spheres never in contact
    add_tol('0);
    add_word(pack_pair(KIND_BOX, KIND_BOX, 0, 0, 0, 0, 0, 0, 48'h0, 48'h0),
             1'b1, CLASS_CONTACT, 1'b0);
    add_word(pack_pair(KIND_SPHERE, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 48'h0, 48'h0),
             1'b1, CLASS_NONE, 1'b0);
    add_word(pack_pair(KIND_SPHERE, KIND_SPHERE, 0, 0, 0, 10, 0, 0,
                       48'h0000_0000_0005, 48'h0000_0000_0005), 1'b0, CLASS_NONE, 1'b0);
    add_word(pack_pair(KIND_BOX, KIND_BOX, 0, 0, 0, 10, 0, 0,
                       48'h0005_0005_0005, 48'h0005_0005_0005), 1'b0, CLASS_NONE, 1'b0);

    phase_tols[0] = 16'hFFFF;
    phase_tols[1] = 16'd0;
    phase_tols[2] = TOL_BITS'($urandom_range(2, 40));
    phase_tols[3] = TOL_BITS'($urandom);
    phase_tols[4] = 16'd1;
    idle_odds[0]  = 4;
    idle_odds[1]  = 2;
    idle_odds[2]  = 8;
    idle_odds[3]  = 3;
    idle_odds[4]  = 4;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_tol) begin
        write_tolerance(row.tol);
      end else begin
        want = row.typed ? row.verdict : classify_pair(row.word, tol_model);
        send_word(row.word, want);
        if ($urandom_range(0, 3) == 0) pause_sender(int'($urandom_range(1, 14)));
      end
    end

    // random phases, one tolerance each; the tail runs back to back
    for (p = 0; p < 5; p++) begin
      write_tolerance(phase_tols[p]);
      for (n = 0; n < PHASE_WORDS; n++) begin
        w = make_pair(tol_model);
        send_word(w, classify_pair(w, tol_model));
        steady = (p == 4) && (n >= PHASE_WORDS - STEADY_WORDS);
        if (p == 1 && n == PHASE_WORDS / 2) drain_results();
        else if (!steady && $urandom_range(1, idle_odds[p]) == 1)
          pause_sender(int'($urandom_range(1, 14)));
      end
    end

    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_verdicts.size() == 0) begin
      $display("PASS bounding_volume_collision_test");
    end else begin
      $display("FAIL bounding_volume_collision_test");
    end
    $finish;
  end

endmodule

// ===== bounding_volume_collision_test.f =====
hdl/bvct_pkg.sv
hdl/bvct_box_test.sv
hdl/bvct_round_test.sv
hdl/bounding_volume_collision_test.sv
tb/bounding_volume_collision_test_test.sv
